### design/craft_tbc_pkg.sv
// shared types, constant tables and nibble functions of the craft tweakable cipher
`default_nettype none
package craft_tbc_pkg;

  localparam int unsigned NumRounds = 32;
  localparam int unsigned LastRound = NumRounds - 1;
  localparam int unsigned CfgIdxW   = 8;

  typedef logic [3:0] nib_t;

  typedef enum logic [CfgIdxW-1:0] {
    KeyHalfZeroIdx = 8'd0,
    KeyHalfOneIdx  = 8'd1
  } cfg_idx_e;

  // data that moves from one round cell to the next
  typedef struct packed {
    logic [63:0] state;
    logic [63:0] tweak;
    logic        func;
  } lane_t;

  localparam nib_t Sbox [16] = '{
    4'hc, 4'ha, 4'hd, 4'h3, 4'he, 4'hb, 4'hf, 4'h7,
    4'h8, 4'h9, 4'h1, 4'h5, 4'h0, 4'h2, 4'h4, 4'h6
  };
  localparam nib_t Perm [16] = '{
    4'hf, 4'hc, 4'hd, 4'he, 4'ha, 4'h9, 4'h8, 4'hb,
    4'h6, 4'h5, 4'h4, 4'h7, 4'h1, 4'h2, 4'h3, 4'h0
  };
  localparam nib_t QPerm [16] = '{
    4'hc, 4'ha, 4'hf, 4'h5, 4'he, 4'h8, 4'h9, 4'h2,
    4'hb, 4'h3, 4'h7, 4'h4, 4'h6, 4'h0, 4'h1, 4'hd
  };
  localparam nib_t Rc3 [NumRounds] = '{
    4'h1, 4'h4, 4'h2, 4'h5, 4'h6, 4'h7, 4'h3, 4'h1,
    4'h4, 4'h2, 4'h5, 4'h6, 4'h7, 4'h3, 4'h1, 4'h4,
    4'h2, 4'h5, 4'h6, 4'h7, 4'h3, 4'h1, 4'h4, 4'h2,
    4'h5, 4'h6, 4'h7, 4'h3, 4'h1, 4'h4, 4'h2, 4'h5
  };
  localparam nib_t Rc4 [NumRounds] = '{
    4'h1, 4'h8, 4'h4, 4'h2, 4'h9, 4'hc, 4'h6, 4'hb,
    4'h5, 4'ha, 4'hd, 4'he, 4'hf, 4'h7, 4'h3, 4'h1,
    4'h8, 4'h4, 4'h2, 4'h9, 4'hc, 4'h6, 4'hb, 4'h5,
    4'ha, 4'hd, 4'he, 4'hf, 4'h7, 4'h3, 4'h1, 4'h8
  };

  // nibble 0 sits in the top four bits
  function automatic nib_t get_nib(logic [63:0] v, logic [3:0] idx);
    return v[7'd63 - {idx, 2'b00} -: 4];
  endfunction

  function automatic logic [63:0] mix_column(logic [63:0] v);
    nib_t        s [16];
    logic [63:0] r;
    for (int i = 0; i < 16; i++) begin
      s[i] = v[63-4*i -: 4];
    end
    for (int i = 0; i < 4; i++) begin
      s[i]   = s[i] ^ s[i+8] ^ s[i+12];
      s[i+4] = s[i+4] ^ s[i+12];
    end
    for (int i = 0; i < 16; i++) begin
      r[63-4*i -: 4] = s[i];
    end
    return r;
  endfunction

  function automatic logic [63:0] q_permute(logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 16; i++) begin
      r[63-4*i -: 4] = get_nib(v, QPerm[i]);
    end
    return r;
  endfunction

  function automatic logic [63:0] perm_sbox(logic [63:0] v);
    nib_t        tmp [16];
    logic [63:0] r;
    for (int i = 0; i < 16; i++) begin
      tmp[Perm[i]] = v[63-4*i -: 4];
    end
    for (int i = 0; i < 16; i++) begin
      r[63-4*i -: 4] = Sbox[tmp[i]];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/craft_tbc_if.sv
// valid/ready channel interfaces for items, results and key writes
`default_nettype none
interface craft_tbc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_in;
  logic [63:0] tweak;
  logic        func;
  modport source (output valid, output block_in, output tweak, output func, input ready);
  modport sink   (input valid, input block_in, input tweak, input func, output ready);
endinterface

interface craft_tbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_out;
  modport source (output valid, output block_out, input ready);
  modport sink   (input valid, input block_out, output ready);
endinterface

interface craft_tbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### design/craft_tweakable_block_cipher.sv
// top level: key registers and a chain of 32 round cells, one block per cycle unless stalled
// an accepted block passes through one register per round cell before its result is valid
// throughput: one block per cycle while the last cell is empty or its result is taken
// reset: rst_ni clears all cell valid bits and both key halves to zero
// the key port is always ready; writes take effect on the next cycle
`default_nettype none
module craft_tweakable_block_cipher
  import craft_tbc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  craft_tbc_in_if.sink    in_ch,
  craft_tbc_out_if.source out_ch,
  craft_tbc_cfg_if.sink   cfg_ch
);

  logic [63:0] key_half_zero_q;
  logic [63:0] key_half_one_q;
  logic        adv;
  logic        valid_chain [NumRounds+1];
  lane_t       lane_chain  [NumRounds+1];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_half_zero_q <= '0;
      key_half_one_q  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        KeyHalfZeroIdx: key_half_zero_q <= cfg_ch.data;
        KeyHalfOneIdx:  key_half_one_q  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // chain moves whenever the last cell is empty or its result is taken
  assign adv          = !valid_chain[NumRounds] || out_ch.ready;
  assign in_ch.ready  = adv;

  assign valid_chain[0]      = in_ch.valid;
  assign lane_chain[0].state = in_ch.block_in;
  assign lane_chain[0].tweak = in_ch.tweak;
  assign lane_chain[0].func  = in_ch.func;

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    craft_tbc_cell #(
      .ROUND_IDX (r)
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .adv_i           (adv),
      .valid_i         (valid_chain[r]),
      .lane_i          (lane_chain[r]),
      .key_half_zero_i (key_half_zero_q),
      .key_half_one_i  (key_half_one_q),
      .valid_o         (valid_chain[r+1]),
      .lane_o          (lane_chain[r+1])
    );
  end

  assign out_ch.valid     = valid_chain[NumRounds];
  assign out_ch.block_out = lane_chain[NumRounds].state;

endmodule
`default_nettype wire

### design/craft_tbc_cell.sv
// one cipher round as a registered cell of the round chain
`default_nettype none
module craft_tbc_cell
  import craft_tbc_pkg::*;
#(
  parameter int unsigned ROUND_IDX = 0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,
  input  wire logic        valid_i,
  input  wire lane_t       lane_i,
  input  wire logic [63:0] key_half_zero_i,
  input  wire logic [63:0] key_half_one_i,
  output logic             valid_o,
  output lane_t            lane_o
);

  localparam logic [1:0] EncSel = 2'(ROUND_IDX % 4);
  localparam logic [1:0] DecSel = 2'(3 - (ROUND_IDX % 4));
  localparam logic [4:0] EncRc  = 5'(ROUND_IDX);
  localparam logic [4:0] DecRc  = 5'(LastRound - ROUND_IDX);

  logic [63:0] tw_q;
  logic [63:0] tk_enc;
  logic [63:0] tk_dec;
  logic [63:0] tk;
  logic [4:0]  rc_idx;
  logic [63:0] added;
  logic [63:0] round_out;
  logic        valid_q;
  lane_t       lane_q;

  // tweakey for this round, mixed in decryption, added with the round constant to the mixed state
  always_comb begin
    tw_q   = q_permute(lane_i.tweak);
    tk_enc = (EncSel[0] ? key_half_one_i : key_half_zero_i) ^
             (EncSel[1] ? tw_q : lane_i.tweak);
    tk_dec = mix_column((DecSel[0] ? key_half_one_i : key_half_zero_i) ^
                        (DecSel[1] ? tw_q : lane_i.tweak));
    tk     = lane_i.func ? tk_dec : tk_enc;
    rc_idx = lane_i.func ? DecRc : EncRc;
    added  = mix_column(lane_i.state);
    added[47:44] = added[47:44] ^ Rc4[rc_idx];
    added[43:40] = added[43:40] ^ Rc3[rc_idx];
    added  = added ^ tk;
  end

  if (ROUND_IDX == LastRound) begin : g_last
    assign round_out = added;
  end else begin : g_mid
    assign round_out = perm_sbox(added);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lane_q.state <= round_out;
      lane_q.tweak <= lane_i.tweak;
      lane_q.func  <= lane_i.func;
    end
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule
`default_nettype wire
